// ----- hdl/dsdl_pkg.sv -----
// Shared types and codes for the depth sorted display list.
`timescale 1ns / 1ps
package dsdl_pkg;

  // Operation codes carried in the op field.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FRONT  = 3'd2;
  localparam logic [2:0] OP_BACK   = 3'd3;
  localparam logic [2:0] OP_SCAN   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Input word of the command channel.
  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         object_id;
    logic signed [15:0] y_key;
  } in_word_t;

  // Output word of the result channel.
  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         out_object_id;
    logic signed [15:0] out_y_key;
    logic [5:0]         entry_total;
    logic               last;
  } out_word_t;

  // One stored list entry.
  typedef struct packed {
    logic [7:0]         handle;
    logic signed [15:0] key;
  } entry_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_SHIFT,
    S_BFRONT,
    S_BBACK,
    S_PLACE,
    S_RESP,
    S_SCAN
  } state_t;

  // Pointer update.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // Entry count update.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_t;

  // Read address relative to the pointer.
  typedef enum logic [2:0] {
    RD_IDX,
    RD_DEC,
    RD_DEC2,
    RD_INC,
    RD_INC2
  } rd_sel_t;

  // Source of the word written at the pointer.
  typedef enum logic {
    WR_RDATA,
    WR_CARRY
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    idx_op_t    idx_op;
    cnt_op_t    cnt_op;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       out_load;
    logic       out_from_rdata;
    logic [1:0] out_status;
    logic       out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_zero;
    logic idx_gt1;
    logic p1_lt;
    logic p2_lt;
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic front_go;
    logic back_go;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/dsdl_stream_if.sv -----
// Valid/ready stream channel carrying one word of a given type.
`timescale 1ns / 1ps
interface dsdl_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/dsdl_datapath.sv -----
// Datapath of the display list: entry memory, pointer, count, carry and output register.
`timescale 1ns / 1ps
module dsdl_datapath import dsdl_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  in_word_t  in_word,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;

  entry_t             mem [CAPACITY];
  entry_t             rdata;
  entry_t             wr_data;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [7:0]         carry_h;
  logic signed [15:0] carry_key;
  logic [XW-1:0]      idx_x;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      rd_addr_x;
  logic [AW-1:0]      rd_addr;
  logic [CW+5:0]      cnt_wide;
  logic               out_free;

  assign idx_x    = {1'b0, idx};
  assign cnt_x    = {1'b0, count};
  assign cnt_wide = {6'b0, count};
  assign out_free = !out_valid || out_ready;

  // Read address is taken relative to the pointer.
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:  rd_addr_x = idx_x;
      RD_DEC:  rd_addr_x = idx_x - XW'(1);
      RD_DEC2: rd_addr_x = idx_x - XW'(2);
      RD_INC:  rd_addr_x = idx_x + XW'(1);
      RD_INC2: rd_addr_x = idx_x + XW'(2);
      default: rd_addr_x = idx_x;
    endcase
  end
  assign rd_addr = rd_addr_x[AW-1:0];

  assign wr_data = (cmd.wr_sel == WR_CARRY) ? entry_t'{handle: carry_h, key: carry_key} : rdata;

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Carry holds the handle and key of the word being placed or searched for.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      carry_h   <= in_word.object_id;
      carry_key <= in_word.y_key;
    end
  end

  // Pointer and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      case (cmd.idx_op)
        IDX_ZERO:  idx <= '0;
        IDX_COUNT: idx <= count;
        IDX_INC:   idx <= idx + CW'(1);
        IDX_DEC:   idx <= idx - CW'(1);
        default:   idx <= idx;
      endcase
      case (cmd.cnt_op)
        CNT_INC:  count <= count + CW'(1);
        CNT_DEC:  count <= count - CW'(1);
        CNT_ZERO: count <= '0;
        default:  count <= count;
      endcase
    end
  end

  // Output register parts the result channel from the work in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.status        <= cmd.out_status;
      out_word.out_object_id <= cmd.out_from_rdata ? rdata.handle : 8'd0;
      out_word.out_y_key     <= cmd.out_from_rdata ? rdata.key : 16'sd0;
      out_word.entry_total   <= cnt_wide[5:0];
      out_word.last          <= cmd.out_last;
    end
  end

  // Status toward the controller.
  assign stat.idx_zero = (idx == '0);
  assign stat.idx_gt1  = (idx > CW'(1));
  assign stat.p1_lt    = ((idx_x + XW'(1)) < cnt_x);
  assign stat.p2_lt    = ((idx_x + XW'(2)) < cnt_x);
  assign stat.cnt_zero = (count == '0);
  assign stat.cnt_full = (count >= CW'(CAPACITY));
  assign stat.match    = (rdata.handle == carry_h);
  assign stat.front_go = ($signed(rdata.key) >= $signed(carry_key));
  assign stat.back_go  = ($signed(rdata.key) <= $signed(carry_key));
  assign stat.out_free = out_free;

endmodule

// ----- hdl/dsdl_ctrl.sv -----
// Controller state machine that sequences each list operation.
`timescale 1ns / 1ps
module dsdl_ctrl import dsdl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] in_op,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  state_t     state, state_next;
  logic [2:0] op_code, op_code_next;
  logic [1:0] status_code, status_code_next;

  // State and operation registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op_code     <= OP_ADD;
      status_code <= ST_OK;
    end else begin
      state       <= state_next;
      op_code     <= op_code_next;
      status_code <= status_code_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next       = state;
    op_code_next     = op_code;
    status_code_next = status_code;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.idx_op       = IDX_HOLD;
    cmd.cnt_op       = CNT_HOLD;
    cmd.rd_sel       = RD_IDX;
    cmd.wr_sel       = WR_RDATA;
    cmd.out_status   = ST_OK;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          op_code_next = in_op;
          cmd.idx_op   = (in_op == OP_ADD) ? IDX_COUNT : IDX_ZERO;
          state_next   = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        status_code_next = ST_OK;
        unique case (op_code) inside
          OP_ADD: begin
            if (stat.cnt_full) begin
              status_code_next = ST_FULL;
              state_next       = S_RESP;
            end else begin
              cmd.cnt_op = CNT_INC;
              if (stat.idx_zero) begin
                state_next = S_PLACE;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_DEC;
                state_next = S_BFRONT;
              end
            end
          end
          OP_REMOVE, OP_FRONT, OP_BACK: begin
            if (stat.cnt_zero) begin
              status_code_next = ST_NOTFOUND;
              state_next       = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_FIND;
            end
          end
          OP_SCAN: begin
            if (stat.cnt_zero) begin
              status_code_next = ST_EMPTY;
              state_next       = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_op = CNT_ZERO;
            state_next = S_RESP;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end

      // The read word is the entry at the pointer.
      S_FIND: begin
        if (stat.match) begin
          if (op_code == OP_REMOVE) begin
            if (stat.p1_lt) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_INC;
              state_next = S_SHIFT;
            end else begin
              cmd.cnt_op = CNT_DEC;
              state_next = S_RESP;
            end
          end else if (op_code == OP_FRONT) begin
            if (stat.idx_zero) begin
              state_next = S_PLACE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_DEC;
              state_next = S_BFRONT;
            end
          end else begin
            if (stat.p1_lt) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_INC;
              state_next = S_BBACK;
            end else begin
              state_next = S_PLACE;
            end
          end
        end else if (stat.p1_lt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_INC;
          cmd.idx_op = IDX_INC;
        end else begin
          status_code_next = ST_NOTFOUND;
          state_next       = S_RESP;
        end
      end

      // The read word is the entry after the pointer; move it down by one.
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_RDATA;
        if (stat.p2_lt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_INC2;
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_RESP;
        end
      end

      // The read word is the entry before the pointer.
      S_BFRONT: begin
        cmd.wr_en = 1'b1;
        if (stat.front_go) begin
          cmd.wr_sel = WR_RDATA;
          cmd.idx_op = IDX_DEC;
          if (stat.idx_gt1) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_DEC2;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          cmd.wr_sel = WR_CARRY;
          state_next = S_RESP;
        end
      end

      // The read word is the entry after the pointer.
      S_BBACK: begin
        cmd.wr_en = 1'b1;
        if (stat.back_go) begin
          cmd.wr_sel = WR_RDATA;
          cmd.idx_op = IDX_INC;
          if (stat.p2_lt) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_INC2;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          cmd.wr_sel = WR_CARRY;
          state_next = S_RESP;
        end
      end

      S_PLACE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_CARRY;
        state_next = S_RESP;
      end

      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = status_code;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end

      // One entry is emitted per cycle while the result channel keeps up.
      S_SCAN: begin
        if (stat.out_free) begin
          cmd.out_load       = 1'b1;
          cmd.out_from_rdata = 1'b1;
          cmd.out_status     = ST_OK;
          cmd.out_last       = !stat.p1_lt;
          if (stat.p1_lt) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_INC;
            cmd.idx_op = IDX_INC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/depth_sorted_display_list.sv -----
// Top level of the depth sorted display list.
//
//   channel  dir  word        handshake
//   cmd      in   in_word_t   valid/ready, taken when both high
//   rsp      out  out_word_t  valid/ready, taken when both high
//
// An operation is set up in the idle and dispatch states, then takes one step per
// entry searched, moved or passed while bubbling, writes the placed entry for an
// add or reorder and posts the result; a scan posts one entry per step, and a full
// add, clear or empty scan goes straight from dispatch to the result.
// The single read port of the entry memory sets one step a cycle.
// Reset is synchronous and empties the list; no clearing pass is needed.
// A stalled result channel holds the controller in its result or scan state.
`timescale 1ns / 1ps
module depth_sorted_display_list import dsdl_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic           clk,
  input logic           rst,
  dsdl_stream_if.sink   cmd,
  dsdl_stream_if.source rsp
);

  dp_cmd_t   dp_cmd;
  dp_stat_t  dp_stat;
  in_word_t  in_word;
  out_word_t out_word;
  logic      out_valid;
  logic      in_ready;

  assign in_word   = cmd.data;
  assign cmd.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  dsdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_op    (in_word.op),
    .in_ready (in_ready),
    .cmd      (dp_cmd),
    .stat     (dp_stat)
  );

  dsdl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (rsp.ready)
  );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the depth sorted display list.
`timescale 1ns / 1ps
module testbench;
  import dsdl_pkg::*;

  localparam int CAPACITY    = 32;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 250;
  localparam int RANDOM_OPS  = 400;
  localparam int SETTLE      = 64;

  // Op codes the block leaves undefined; they must answer ok and change nothing.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // One row of the directed table; when typed is set the result word is given here.
  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         id;
    logic signed [15:0] key;
    logic               typed;
    logic [1:0]         st;
    logic [5:0]         total;
  } dir_row_t;

  logic clk;
  logic rst;

  dsdl_stream_if #(.T(in_word_t))  cmd_ch ();
  dsdl_stream_if #(.T(out_word_t)) rsp_ch ();

  depth_sorted_display_list #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list as the block should hold it.
  logic [7:0]         list_handle [CAPACITY];
  logic signed [15:0] list_key [CAPACITY];
  int                 list_len;

  out_word_t expected_results[$];

  int  fail_count;
  int  result_index;
  int  cmds_sent;
  int  scans_seen;
  int  full_seen;
  int  notfound_seen;
  bit  hold_request;
  bit  no_idle;

  dir_row_t directed_rows [0:23] = '{
    // Empty list: scan, then every handle lookup misses.
    '{OP_SCAN,   8'h00, 16'sh0000, 1'b1, ST_EMPTY,    6'd0},
    '{OP_REMOVE, 8'h00, 16'sh0000, 1'b1, ST_NOTFOUND, 6'd0},
    '{OP_FRONT,  8'hFF, 16'sh7FFF, 1'b1, ST_NOTFOUND, 6'd0},
    '{OP_BACK,   8'h55, 16'sh8000, 1'b1, ST_NOTFOUND, 6'd0},
    // Extremes of handle and key, equal keys and a duplicate handle; then reorder, remove, spare codes and clear.
    '{OP_ADD,    8'h00, 16'sh0000, 1'b1, ST_OK,       6'd1},
    '{OP_ADD,    8'hFF, 16'sh7FFF, 1'b1, ST_OK,       6'd2},
    '{OP_ADD,    8'h80, 16'sh8000, 1'b1, ST_OK,       6'd3},
    '{OP_ADD,    8'h7F, 16'sh0000, 1'b1, ST_OK,       6'd4},
    '{OP_ADD,    8'h7F, 16'sh0000, 1'b1, ST_OK,       6'd5},
    '{OP_SCAN,   8'h00, 16'sh0000, 1'b0, ST_OK,       6'd0},
    '{OP_FRONT,  8'h7F, 16'sh8000, 1'b0, ST_OK,       6'd0},
    '{OP_BACK,   8'h00, 16'sh7FFF, 1'b0, ST_OK,       6'd0},
    '{OP_SCAN,   8'h00, 16'sh0000, 1'b0, ST_OK,       6'd0},
    '{OP_REMOVE, 8'h7F, 16'sh0000, 1'b1, ST_OK,       6'd4},
    '{OP_SPARE6, 8'h00, 16'sh0000, 1'b1, ST_OK,       6'd4},
    '{OP_SPARE7, 8'hFF, 16'shFFFF, 1'b1, ST_OK,       6'd4},
    '{OP_SCAN,   8'h00, 16'sh0000, 1'b0, ST_OK,       6'd0},
    '{OP_CLEAR,  8'h00, 16'sh0000, 1'b1, ST_OK,       6'd0},
    '{OP_SCAN,   8'h00, 16'sh0000, 1'b1, ST_EMPTY,    6'd0},
    // A single entry reordered both ways.
    '{OP_ADD,    8'hAA, 16'shFFFF, 1'b1, ST_OK,       6'd1},
    '{OP_BACK,   8'hAA, 16'sh1234, 1'b1, ST_OK,       6'd1},
    '{OP_FRONT,  8'hAA, 16'shFFFB, 1'b1, ST_OK,       6'd1},
    '{OP_SCAN,   8'h00, 16'sh0000, 1'b0, ST_OK,       6'd0},
    '{OP_CLEAR,  8'h00, 16'sh0000, 1'b1, ST_OK,       6'd0}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("tb: mismatch in result %0d, %s: got %0d, expected %0d",
             result_index, what, got_v, want_v);
    fail_count++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [7:0]         h;
    logic signed [15:0] k;
    h = list_handle[a];
    k = list_key[a];
    list_handle[a] = list_handle[b];
    list_key[a] = list_key[b];
    list_handle[b] = h;
    list_key[b] = k;
  endfunction

  function automatic int find_first(input logic [7:0] h);
    for (int i = 0; i < list_len; i++) begin
      if (list_handle[i] == h) return i;
    end
    return list_len;
  endfunction

  function automatic void sink_toward_front(input int start);
    int pos;
    pos = start;
    while (pos > 0 && list_key[pos - 1] >= list_key[pos]) begin
      swap_slots(pos - 1, pos);
      pos--;
    end
  endfunction

  // Apply one command word to the shadow list and queue the result words it causes.
  function automatic void apply_list_op(input in_word_t w);
    logic [1:0] st;
    int         pos;
    st = ST_OK;
    case (w.op)
      OP_ADD: begin
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
          full_seen++;
        end else begin
          list_handle[list_len] = w.object_id;
          list_key[list_len] = w.y_key;
          list_len++;
          sink_toward_front(list_len - 1);
        end
      end
      OP_REMOVE: begin
        pos = find_first(w.object_id);
        if (pos >= list_len) begin
          st = ST_NOTFOUND;
          notfound_seen++;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) begin
            list_handle[i] = list_handle[i + 1];
            list_key[i] = list_key[i + 1];
          end
          list_len--;
        end
      end
      OP_FRONT, OP_BACK: begin
        pos = find_first(w.object_id);
        if (pos >= list_len) begin
          st = ST_NOTFOUND;
          notfound_seen++;
        end else begin
          list_key[pos] = w.y_key;
          if (w.op == OP_FRONT) begin
            sink_toward_front(pos);
          end else begin
            while (pos + 1 < list_len && list_key[pos + 1] <= list_key[pos]) begin
              swap_slots(pos, pos + 1);
              pos++;
            end
          end
        end
      end
      OP_SCAN: begin
        scans_seen++;
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            expected_results.push_back('{ST_OK, list_handle[i], list_key[i],
                                         6'(list_len), (i + 1 == list_len)});
          end
          return;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    expected_results.push_back('{st, 8'h00, 16'sh0000, 6'(list_len), 1'b1});
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random command word; handles mostly come from the list so lookups hit.
  function automatic in_word_t random_item(input bit grow);
    in_word_t w;
    int       r;
    int       add_pct;
    int       small_v;
    r = $urandom_range(0, 99);
    add_pct = grow ? 55 : 28;
    if (r < add_pct) w.op = OP_ADD;
    else if (r < add_pct + 14) w.op = OP_REMOVE;
    else if (r < add_pct + 26) w.op = OP_FRONT;
    else if (r < add_pct + 38) w.op = OP_BACK;
    else if (r < add_pct + 46) w.op = OP_SCAN;
    else if (r < add_pct + 48) w.op = OP_CLEAR;
    else if (r < add_pct + 50) w.op = OP_SPARE6;
    else if (r < add_pct + 52) w.op = OP_SPARE7;
    else w.op = OP_FRONT;
    r = $urandom_range(0, 9);
    if (list_len > 0 && r < 7) w.object_id = list_handle[$urandom_range(0, list_len - 1)];
    else if (r < 8) w.object_id = 8'($urandom_range(0, 15));
    else w.object_id = 8'($urandom);
    small_v = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0: w.y_key = 16'sh8000;
      1: w.y_key = 16'sh7FFF;
      2, 3, 4: w.y_key = 16'(small_v - 3);
      default: w.y_key = 16'($urandom);
    endcase
    return w;
  endfunction

  // Offer one word until it is taken, then record its expected results.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_word);
    int gap;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    apply_list_op(w);
    cmds_sent++;
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(typed_word);
    end
    gap = idle_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input bit grow);
    send_word(random_item(grow), 1'b0, '0);
  endtask

  // Stop offering and wait until every expected result word has come back.
  task automatic wait_results_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result side: check every accepted word and idle ready at random.
  initial begin
    int stall_left;
    bit hold_taken;
    out_word_t got;
    out_word_t want;
    stall_left = 0;
    hold_taken = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
          got = rsp_ch.data;
          if (expected_results.size() == 0) begin
            report_mismatch("word with nothing pending, handle", got.out_object_id, -1);
          end else begin
            want = expected_results.pop_front();
            if (got.status != want.status)
              report_mismatch("status", got.status, want.status);
            if (got.out_object_id != want.out_object_id)
              report_mismatch("out_object_id", got.out_object_id, want.out_object_id);
            if (got.out_y_key != want.out_y_key)
              report_mismatch("out_y_key", got.out_y_key, want.out_y_key);
            if (got.entry_total != want.entry_total)
              report_mismatch("entry_total", got.entry_total, want.entry_total);
            if (got.last != want.last)
              report_mismatch("last", got.last, want.last);
          end
          result_index++;
        end
        if (stall_left > 0) begin
          rsp_ch.ready <= 1'b0;
          stall_left--;
        end else if (hold_request && !hold_taken) begin
          // Long hold-off so the block fills up and stalls its command side.
          hold_taken = 1'b1;
          stall_left = LONG_HOLD - 1;
          rsp_ch.ready <= 1'b0;
        end else begin
          stall_left = idle_gap();
          if (stall_left == 0) begin
            rsp_ch.ready <= 1'b1;
          end else begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: timeout after %0d cycles", cycles);
    $display("tb: failure");
    $finish;
  end

  // Stimulus.
  initial begin
    in_word_t w;
    dir_row_t row;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    list_len = 0;
    fail_count = 0;
    result_index = 0;
    cmds_sent = 0;
    scans_seen = 0;
    full_seen = 0;
    notfound_seen = 0;
    hold_request = 1'b0;
    no_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      w = '{row.op, row.id, row.key};
      send_word(w, row.typed, '{row.st, 8'h00, 16'sh0000, row.total, 1'b1});
    end
    wait_results_drained();

    // Random commands, alternating between growing and mixed stretches.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 120) hold_request = 1'b1;
      no_idle = (n >= 160 && n < 200);
      if (n == 220) wait_results_drained();
      if (n == 300) begin
        // Fill the list to capacity, then push against the full list.
        while (list_len < CAPACITY) begin
          w = random_item(1'b1);
          w.op = OP_ADD;
          send_word(w, 1'b0, '0);
        end
        w.op = OP_ADD;
        w.object_id = 8'($urandom);
        send_word(w, 1'b1, '{ST_FULL, 8'h00, 16'sh0000, 6'(CAPACITY), 1'b1});
        w.op = OP_SCAN;
        send_word(w, 1'b0, '0);
      end
      send_random(((n / 50) % 2) == 0);
    end

    // Let the last results come back, then watch for strays.
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);

    $display("tb: %0d commands, %0d result words, %0d scans", cmds_sent, result_index,
             scans_seen);
    $display("tb: %0d adds into a full list, %0d missing-handle lookups, %0d mismatches",
             full_seen, notfound_seen, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/dsdl_pkg.sv
hdl/dsdl_stream_if.sv
hdl/dsdl_datapath.sv
hdl/dsdl_ctrl.sv
hdl/depth_sorted_display_list.sv
sim/testbench.sv
